// ----- hdl/nls_pkg.sv -----
package nls_pkg;

   localparam int INPUT_BITS    = 16;
   localparam int SERIES_TERMS  = 7;
   localparam int FRACTION_BITS = 28;
   localparam int SUM_W         = 32;

   // odd base 2k+1, one bit wider than the input
   localparam int A_W    = INPUT_BITS + 1;
   // power and divisor never exceed 2^(FRACTION_BITS+1)
   localparam int P_W    = FRACTION_BITS + 2;
   localparam int PROD_W = P_W + A_W;
   localparam int I_W    = (SERIES_TERMS > 1) ? $clog2(SERIES_TERMS) : 1;
   localparam int M_W    = I_W + 1;
   localparam int CNT_W  = $clog2(P_W + 1);

   localparam logic [PROD_W-1:0] NUM = PROD_W'(1) << (FRACTION_BITS + 1);

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_KINIT,
      OP_MUL_A,
      OP_TAKE_P,
      OP_MUL_M,
      OP_DIV,
      OP_ACC,
      OP_KINC,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_N_SMALL,
      C_PROD_OVER,
      C_M_ONE,
      C_DIV_BUSY,
      C_I_LAST,
      C_K_LAST,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic n_small;
      logic prod_over;
      logic m_one;
      logic div_busy;
      logic i_last;
      logic k_last;
      logic out_busy;
   } status_type;

endpackage

// ----- hdl/natural_log_series.sv -----
// Natural logarithm of a 16-bit natural number n, returned as unsigned Q4.28
// with input_error set (and a zero result) when n is below 2. ln(n) is the
// sum over k = 1 .. n-1 of up to seven odd terms 2/(m*(2k+1)^m), each
// truncated to 28 fraction bits; a k step ends at the first term whose
// divisor exceeds 2^29. A small microcode program drives one shared
// multiplier and a restoring divider. Each term waits on the divider, so the
// work for an item grows with the number of terms and with n; an input below
// 2 skips the series and goes straight to the output step. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is taken.
module natural_log_series
   import nls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [INPUT_BITS-1:0] req_tdata,  // [15:0] number_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SUM_W-1:0]      rsp_tdata,  // [31:0] log_value
   output logic [0:0]            rsp_tuser   // [0] input_error
);

   ctrl_type   ctrl;
   status_type status;

   nls_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   nls_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a flagged item always carries a zero logarithm
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("error item with nonzero result");

   // the divider is only restarted once it has finished
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_DIV |-> !status.div_busy)
      else $error("divider restarted while busy");

   // a new result appears only from the output step of the program
   a_out_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl.op == OP_OUT))
      else $error("result raised outside the output step");

endmodule

// ----- hdl/nls_divider.sv -----
module nls_divider
   import nls_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [P_W-1:0] divisor,
   output logic           busy,
   output logic [P_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [P_W-1:0]   rem_ff, rem_in;
   logic [P_W-1:0]   q_ff, q_in;
   logic [P_W-1:0]   d_ff, d_in;
   logic [P_W:0]     trial;
   logic             fits;

   // restoring division of the fixed numerator, one quotient bit per cycle
   assign trial = {rem_ff, q_ff[P_W-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(P_W);
         rem_in  = '0;
         q_in    = NUM[P_W-1:0];
         d_in    = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = P_W'(trial - {1'b0, d_ff});
         end else begin
            rem_in = trial[P_W-1:0];
         end
         q_in   = {q_ff[P_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

// ----- hdl/nls_datapath.sv -----
module nls_datapath
   import nls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_type              ctrl,
   output status_type            status,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [INPUT_BITS-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SUM_W-1:0]      rsp_tdata,
   output logic [0:0]            rsp_tuser
);

   logic [INPUT_BITS-1:0] n_ff, n_in;
   logic [INPUT_BITS-1:0] k_ff, k_in;
   logic [A_W-1:0]        a_ff, a_in;
   logic [P_W-1:0]        p_ff, p_in;
   logic [I_W-1:0]        i_ff, i_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  err_ff, err_in;
   logic                  out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]      out_data_ff, out_data_in;
   logic                  out_err_ff, out_err_in;

   logic                  accept;
   logic                  out_busy;
   logic                  prod_over;
   logic [M_W-1:0]        m_val;
   logic [A_W-1:0]        mul_b;
   logic [SUM_W:0]        sum_wide;
   logic                  div_start;
   logic                  div_busy;
   logic [P_W-1:0]        quot;

   assign req_tready = (ctrl.op == OP_LOAD);
   assign accept     = req_tready && req_tvalid;
   assign out_busy   = out_valid_ff && !rsp_tready;
   assign prod_over  = prod_ff > NUM;
   assign m_val      = {i_ff, 1'b1};
   assign mul_b      = (ctrl.op == OP_MUL_M) ? A_W'(m_val) : a_ff;
   assign sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(quot);
   // a divisor that overflowed the numerator ends the k step, no division
   assign div_start  = (ctrl.op == OP_DIV) && !prod_over;

   nls_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (prod_ff[P_W-1:0]),
      .busy     (div_busy),
      .quotient (quot)
   );

   always_comb begin
      n_in    = n_ff;
      k_in    = k_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      i_in    = i_ff;
      prod_in = prod_ff;
      sum_in  = sum_ff;
      err_in  = err_ff;
      unique case (ctrl.op) inside
         OP_LOAD: begin
            if (accept) begin
               n_in   = req_tdata;
               k_in   = INPUT_BITS'(1);
               sum_in = '0;
               err_in = req_tdata < INPUT_BITS'(2);
            end
         end
         OP_KINIT: begin
            a_in = {k_ff, 1'b1};
            p_in = P_W'(1);
            i_in = '0;
         end
         OP_MUL_A, OP_MUL_M: begin
            prod_in = PROD_W'(p_ff) * PROD_W'(mul_b);
         end
         OP_TAKE_P: begin
            p_in = prod_ff[P_W-1:0];
         end
         OP_ACC: begin
            sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            i_in   = i_ff + I_W'(1);
         end
         OP_KINC: begin
            k_in = k_ff + INPUT_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   // output register parts the sequencer from a stalled consumer
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_err_in   = out_err_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (ctrl.op == OP_OUT && !out_busy) begin
         out_valid_in = 1'b1;
         out_data_in  = sum_ff;
         out_err_in   = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         err_ff       <= err_in;
      end
      n_ff        <= n_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      out_data_ff <= out_data_in;
      out_err_ff  <= out_err_in;
   end

   always_comb begin
      status.no_req    = !req_tvalid;
      status.n_small   = err_ff;
      status.prod_over = prod_over;
      status.m_one     = (i_ff == '0);
      status.div_busy  = div_busy;
      status.i_last    = (i_ff == I_W'(SERIES_TERMS - 1));
      status.k_last    = ({1'b0, k_ff} + (INPUT_BITS + 1)'(1)) == {1'b0, n_ff};
      status.out_busy  = out_busy;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

// ----- hdl/nls_sequencer.sv -----
module nls_sequencer
   import nls_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   localparam int UPC_W = 5;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } uword_type;

   localparam logic [UPC_W-1:0] S_IDLE   = UPC_W'(0);
   localparam logic [UPC_W-1:0] S_KINIT  = UPC_W'(2);
   localparam logic [UPC_W-1:0] S_MUL1   = UPC_W'(3);
   localparam logic [UPC_W-1:0] S_MULM   = UPC_W'(8);
   localparam logic [UPC_W-1:0] S_DIVW   = UPC_W'(10);
   localparam logic [UPC_W-1:0] S_NEXTK  = UPC_W'(13);
   localparam logic [UPC_W-1:0] S_FINISH = UPC_W'(15);

   function automatic uword_type urom(input logic [UPC_W-1:0] addr);
      uword_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
      unique case (addr)
         5'd0:  w = '{op: OP_LOAD,   cond: C_NO_REQ,    target: S_IDLE};
         5'd1:  w = '{op: OP_NOP,    cond: C_N_SMALL,   target: S_FINISH};
         5'd2:  w = '{op: OP_KINIT,  cond: C_NEVER,     target: S_IDLE};
         5'd3:  w = '{op: OP_MUL_A,  cond: C_NEVER,     target: S_IDLE};
         5'd4:  w = '{op: OP_TAKE_P, cond: C_PROD_OVER, target: S_NEXTK};
         // first term needs a single power of the base
         5'd5:  w = '{op: OP_NOP,    cond: C_M_ONE,     target: S_MULM};
         5'd6:  w = '{op: OP_MUL_A,  cond: C_NEVER,     target: S_IDLE};
         5'd7:  w = '{op: OP_TAKE_P, cond: C_PROD_OVER, target: S_NEXTK};
         5'd8:  w = '{op: OP_MUL_M,  cond: C_NEVER,     target: S_IDLE};
         5'd9:  w = '{op: OP_DIV,    cond: C_PROD_OVER, target: S_NEXTK};
         5'd10: w = '{op: OP_NOP,    cond: C_DIV_BUSY,  target: S_DIVW};
         5'd11: w = '{op: OP_ACC,    cond: C_I_LAST,    target: S_NEXTK};
         5'd12: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: S_MUL1};
         5'd13: w = '{op: OP_KINC,   cond: C_K_LAST,    target: S_FINISH};
         5'd14: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: S_KINIT};
         5'd15: w = '{op: OP_OUT,    cond: C_OUT_BUSY,  target: S_FINISH};
         5'd16: w = '{op: OP_NOP,    cond: C_ALWAYS,    target: S_IDLE};
         default: w = '{op: OP_NOP,  cond: C_ALWAYS,    target: S_IDLE};
      endcase
      return w;
   endfunction

   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        word;
   logic             take;

   assign word = urom(upc_ff);

   always_comb begin
      unique case (word.cond)
         C_NEVER:     take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_REQ:    take = status.no_req;
         C_N_SMALL:   take = status.n_small;
         C_PROD_OVER: take = status.prod_over;
         C_M_ONE:     take = status.m_one;
         C_DIV_BUSY:  take = status.div_busy;
         C_I_LAST:    take = status.i_last;
         C_K_LAST:    take = status.k_last;
         C_OUT_BUSY:  take = status.out_busy;
         default:     take = 1'b0;
      endcase
      upc_in = take ? word.target : upc_ff + UPC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl.op = word.op;

endmodule

// ----- test/natural_log_series_tb.sv -----
module natural_log_series_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nls_pkg::*;

   typedef struct {
      logic [SUM_W-1:0] log_value;
      logic             input_error;
   } log_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [INPUT_BITS-1:0] req_tdata = '0;   // [15:0] number_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SUM_W-1:0]      rsp_tdata;        // [31:0] log_value
   logic [0:0]            rsp_tuser;        // [0] input_error

   natural_log_series DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [INPUT_BITS-1:0] numbers_to_send[$];
   log_result_type        logs_due[$];
   logic                  req_fire = 1'b0;
   int                    mismatches = 0;
   int                    numbers_sent = 0;
   int                    logs_checked = 0;
   int                    errors_seen = 0;
   int                    largest_number = 0;

   // ln(n) as the sum of truncated atanh series terms, Q4.28
   function automatic log_result_type predict_log(input logic [INPUT_BITS-1:0] n);
      log_result_type res;
      logic [63:0] num;
      logic [63:0] sum;
      logic [63:0] a;
      logic [63:0] m;
      logic [63:0] p;
      logic        fits;
      num = 64'd1 << (FRACTION_BITS + 1);
      sum = '0;
      res.input_error = (n < 2);
      for (longint k = 1; k < n; k++) begin
         a = 2 * k + 1;
         for (int i = 0; i < SERIES_TERMS; i++) begin
            m = 2 * i + 1;
            p = 64'd1;
            fits = 1'b1;
            for (int e = 0; e < m; e++) begin
               if (fits) begin
                  if (p > num / a) fits = 1'b0;
                  else p = p * a;
               end
            end
            if (fits && p > num / m) fits = 1'b0;
            // vanishing term: the rest of this k contributes nothing
            if (!fits) break;
            sum = sum + num / (m * p);
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
         end
      end
      res.log_value = sum[SUM_W-1:0];
      return res;
   endfunction

   // sender: bursts of random length separated by random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (numbers_to_send.size() > 0) begin
            req_tdata <= numbers_to_send.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 8);
               gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                                       : $urandom_range(0, 4);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: rotating stall pattern, replaced now and then
   logic [15:0] stall_pattern = 16'hFFFF;
   int          pattern_age = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern <= 16'hFFFF;
               1: stall_pattern <= 16'($urandom) | (16'd1 << $urandom_range(0, 15));
               2: stall_pattern <= 16'($urandom & $urandom) | 16'd1;
               default: stall_pattern <= ~(16'd1 << $urandom_range(0, 15));
            endcase
            pattern_age <= $urandom_range(32, 256);
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            pattern_age <= pattern_age - 1;
         end
         rsp_tready <= stall_pattern[0];
      end
   end

   // monitor on both channels
   always @(posedge clock) begin
      log_result_type want;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            logs_due.push_back(predict_log(req_tdata));
            numbers_sent++;
            if (req_tdata > largest_number) largest_number = req_tdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (logs_due.size() == 0) begin
               $error("log_value %0h arrived with no item outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = logs_due.pop_front();
               if (rsp_tdata !== want.log_value) begin
                  $error("log_value: expected %0h, got %0h", want.log_value, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.input_error) begin
                  $error("input_error: expected %0b, got %0b",
                         want.input_error, rsp_tuser[0]);
                  mismatches++;
               end
               if (want.input_error) errors_seen++;
               logs_checked++;
            end
         end
      end
   end

   initial begin
      int pick;
      // extremes, back-to-back rejects, a full-length k = 1 step and vanishing terms
      numbers_to_send = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd0, 16'd1, 16'd4, 16'd5,
                          16'd8, 16'd16, 16'd100, 16'd255, 16'd256, 16'd1,
                          16'd65535, 16'd0, 16'd2, 16'd1000, 16'd1024, 16'd2};
      for (int j = 0; j < 80; j++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            numbers_to_send.push_back(INPUT_BITS'($urandom_range(0, 3)));
         end else if (pick < 75) begin
            numbers_to_send.push_back(INPUT_BITS'($urandom_range(4, 255)));
         end else if (pick < 95) begin
            numbers_to_send.push_back(INPUT_BITS'($urandom_range(256, 1023)));
         end else begin
            numbers_to_send.push_back(INPUT_BITS'($urandom_range(1024, 4095)));
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (numbers_to_send.size() > 0 || req_tvalid) @(posedge clock);
      while (logs_due.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d numbers sent (largest %0d), %0d logarithms checked, %0d rejected inputs",
               numbers_sent, largest_number, logs_checked, errors_seen);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #480_000_000;
      $display("timed out with %0d results outstanding", logs_due.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
